@@ rtl/tbr_pkg.sv @@
// shared types, constants and helpers for the triangle barycentric rasterizer
package tbr_pkg;

    // largest raster size honored in either direction
    localparam logic [16:0] MAX_DIM = 17'd4096;

    localparam int unsigned PIX_W   = 12;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned AREA_W  = 34;
    localparam int unsigned NUM_W   = 67;
    localparam int unsigned DEN_W   = 35;
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned CFG_A_W = 3;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_VERTEX_A      = 3'd0,
        CFG_VERTEX_B      = 3'd1,
        CFG_VERTEX_C      = 3'd2,
        CFG_RASTER_WIDTH  = 3'd3,
        CFG_RASTER_HEIGHT = 3'd4
    } t_cfg_addr;

    // x and y unsigned Q12.4, z signed Q16.16
    typedef struct packed {
        logic [15:0]        x;
        logic [15:0]        y;
        logic signed [31:0] z;
    } t_vertex;

    typedef struct packed {
        logic [PIX_W-1:0] mem_row;
        logic [PIX_W-1:0] mem_col;
    } t_pix;

    // edge-function results with the area sign folded to non-negative
    typedef struct packed {
        logic              in_tri;
        logic [AREA_W-1:0] d;
        logic [AREA_W-1:0] n1;
        logic [AREA_W-1:0] n2;
        logic [AREA_W-1:0] n3;
    } t_edge;

    typedef struct packed {
        logic en;
        t_pix pix;
    } t_side;

    function automatic logic [15:0] min3(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c);
        logic [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [15:0] max3(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c);
        logic [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return ({4'b0, v} > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : v;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_to(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

@@ rtl/tbr_edge.sv @@
// edge functions, area sign fold, inside and bounding box tests (six stages)
module tbr_edge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ce,
    input  logic                       i_vld,
    input  logic [tbr_pkg::PIX_W-1:0]  i_col,
    input  logic [tbr_pkg::PIX_W-1:0]  i_row,
    input  tbr_pkg::t_vertex           i_vtx_a,
    input  tbr_pkg::t_vertex           i_vtx_b,
    input  tbr_pkg::t_vertex           i_vtx_c,
    input  logic [tbr_pkg::DIM_W-1:0]  i_raster_w,
    input  logic [tbr_pkg::DIM_W-1:0]  i_raster_h,
    output logic                       o_vld,
    output tbr_pkg::t_edge             o_edge,
    output tbr_pkg::t_pix              o_pix
);

    // stage 1: coordinate differences, box limits, flipped row
    logic signed [16:0] n1_dy_bc, n1_dx_cb, n1_dx_ac, n1_dy_ac, n1_dy_ca, n1_px_c, n1_py_c;
    logic [tbr_pkg::DIM_W-1:0] n1_rs, n1_re, n1_cs, n1_ce;
    tbr_pkg::t_pix             n1_pix;
    logic [tbr_pkg::PIX_W-1:0] n1_row;

    logic signed [16:0] r1_dy_bc, r1_dx_cb, r1_dx_ac, r1_dy_ac, r1_dy_ca, r1_px_c, r1_py_c;
    logic [tbr_pkg::DIM_W-1:0] r1_rs, r1_re, r1_cs, r1_ce;
    tbr_pkg::t_pix             r1_pix;
    logic [tbr_pkg::PIX_W-1:0] r1_row;
    logic                      r1_vld;

    always_comb begin
        logic signed [16:0] ax, ay, bx, by, cx, cy, px, py;
        logic [tbr_pkg::DIM_W-1:0] w, h;
        logic [16:0] lo_y, hi_y, lo_x, hi_x;
        ax = $signed({1'b0, i_vtx_a.x});
        ay = $signed({1'b0, i_vtx_a.y});
        bx = $signed({1'b0, i_vtx_b.x});
        by = $signed({1'b0, i_vtx_b.y});
        cx = $signed({1'b0, i_vtx_c.x});
        cy = $signed({1'b0, i_vtx_c.y});
        // pixel centre in 1/16 units
        px = $signed({1'b0, i_col, 4'b1000});
        py = $signed({1'b0, i_row, 4'b1000});
        n1_dy_bc = by - cy;
        n1_dx_cb = cx - bx;
        n1_dx_ac = ax - cx;
        n1_dy_ac = ay - cy;
        n1_dy_ca = cy - ay;
        n1_px_c  = px - cx;
        n1_py_c  = py - cy;
        w = tbr_pkg::clamp_dim(i_raster_w);
        h = tbr_pkg::clamp_dim(i_raster_h);
        lo_y = {1'b0, tbr_pkg::min3(i_vtx_a.y, i_vtx_b.y, i_vtx_c.y)} + 17'd8;
        hi_y = {1'b0, tbr_pkg::max3(i_vtx_a.y, i_vtx_b.y, i_vtx_c.y)} + 17'd24;
        lo_x = {1'b0, tbr_pkg::min3(i_vtx_a.x, i_vtx_b.x, i_vtx_c.x)} + 17'd8;
        hi_x = {1'b0, tbr_pkg::max3(i_vtx_a.x, i_vtx_b.x, i_vtx_c.x)} + 17'd24;
        n1_rs = tbr_pkg::clamp_to(lo_y[16:4], h);
        n1_re = tbr_pkg::clamp_to(hi_y[16:4], h);
        n1_cs = tbr_pkg::clamp_to(lo_x[16:4], w);
        n1_ce = tbr_pkg::clamp_to(hi_x[16:4], w);
        n1_pix.mem_row = h[tbr_pkg::PIX_W-1:0] - 12'd1 - i_row;
        n1_pix.mem_col = i_col;
        n1_row = i_row;
    end

    // stage 2: products and box test
    logic signed [33:0] n2_pd1, n2_pd2, n2_pn1a, n2_pn1b, n2_pn2a, n2_pn2b;
    logic               n2_in_box;
    logic signed [33:0] r2_pd1, r2_pd2, r2_pn1a, r2_pn1b, r2_pn2a, r2_pn2b;
    logic               r2_in_box;
    tbr_pkg::t_pix      r2_pix;
    logic               r2_vld;

    always_comb begin
        n2_pd1  = r1_dy_bc * r1_dx_ac;
        n2_pd2  = r1_dx_cb * r1_dy_ac;
        n2_pn1a = r1_dy_bc * r1_px_c;
        n2_pn1b = r1_dx_cb * r1_py_c;
        n2_pn2a = r1_dy_ca * r1_px_c;
        n2_pn2b = r1_dx_ac * r1_py_c;
        n2_in_box = ({1'b0, r1_row} >= r1_rs) && ({1'b0, r1_row} < r1_re) &&
                    ({1'b0, r1_pix.mem_col} >= r1_cs) && ({1'b0, r1_pix.mem_col} < r1_ce);
    end

    // stage 3: raw area and first two weights
    logic signed [34:0] n3_d, n3_n1, n3_n2;
    logic signed [34:0] r3_d, r3_n1, r3_n2;
    logic               r3_in_box;
    tbr_pkg::t_pix      r3_pix;
    logic               r3_vld;

    always_comb begin
        n3_d  = r2_pd1 + r2_pd2;
        n3_n1 = r2_pn1a + r2_pn1b;
        n3_n2 = r2_pn2a + r2_pn2b;
    end

    // stage 4: fold the winding so the area is non-negative
    logic signed [34:0] n4_d, n4_n1, n4_n2;
    logic signed [34:0] r4_d, r4_n1, r4_n2;
    logic               r4_in_box;
    tbr_pkg::t_pix      r4_pix;
    logic               r4_vld;

    always_comb begin
        n4_d  = r3_d[34] ? -r3_d  : r3_d;
        n4_n1 = r3_d[34] ? -r3_n1 : r3_n1;
        n4_n2 = r3_d[34] ? -r3_n2 : r3_n2;
    end

    // stage 5: third weight and tests on the first two
    logic signed [36:0] n5_n3;
    logic               n5_ok;
    logic signed [36:0] r5_n3;
    logic signed [34:0] r5_d, r5_n1, r5_n2;
    logic               r5_ok, r5_in_box;
    tbr_pkg::t_pix      r5_pix;
    logic               r5_vld;

    always_comb begin
        n5_n3 = r4_d - r4_n1 - r4_n2;
        n5_ok = (r4_d != 35'sd0) &&
                !r4_n1[34] && (r4_n1 <= r4_d) &&
                !r4_n2[34] && (r4_n2 <= r4_d);
    end

    // stage 6: final inside decision
    logic          n6_in;
    tbr_pkg::t_edge r6_edge;
    tbr_pkg::t_pix  r6_pix;
    logic           r6_vld;

    always_comb begin
        n6_in = r5_ok && r5_in_box && !r5_n3[36] && (r5_n3 <= r5_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_dy_bc <= n1_dy_bc;
            r1_dx_cb <= n1_dx_cb;
            r1_dx_ac <= n1_dx_ac;
            r1_dy_ac <= n1_dy_ac;
            r1_dy_ca <= n1_dy_ca;
            r1_px_c  <= n1_px_c;
            r1_py_c  <= n1_py_c;
            r1_rs    <= n1_rs;
            r1_re    <= n1_re;
            r1_cs    <= n1_cs;
            r1_ce    <= n1_ce;
            r1_pix   <= n1_pix;
            r1_row   <= n1_row;

            r2_pd1    <= n2_pd1;
            r2_pd2    <= n2_pd2;
            r2_pn1a   <= n2_pn1a;
            r2_pn1b   <= n2_pn1b;
            r2_pn2a   <= n2_pn2a;
            r2_pn2b   <= n2_pn2b;
            r2_in_box <= n2_in_box;
            r2_pix    <= r1_pix;

            r3_d      <= n3_d;
            r3_n1     <= n3_n1;
            r3_n2     <= n3_n2;
            r3_in_box <= r2_in_box;
            r3_pix    <= r2_pix;

            r4_d      <= n4_d;
            r4_n1     <= n4_n1;
            r4_n2     <= n4_n2;
            r4_in_box <= r3_in_box;
            r4_pix    <= r3_pix;

            r5_n3     <= n5_n3;
            r5_d      <= r4_d;
            r5_n1     <= r4_n1;
            r5_n2     <= r4_n2;
            r5_ok     <= n5_ok;
            r5_in_box <= r4_in_box;
            r5_pix    <= r4_pix;

            r6_edge.in_tri <= n6_in;
            r6_edge.d      <= r5_d[tbr_pkg::AREA_W-1:0];
            r6_edge.n1     <= r5_n1[tbr_pkg::AREA_W-1:0];
            r6_edge.n2     <= r5_n2[tbr_pkg::AREA_W-1:0];
            r6_edge.n3     <= r5_n3[tbr_pkg::AREA_W-1:0];
            r6_pix         <= r5_pix;
        end
    end

    assign o_vld  = r6_vld;
    assign o_edge = r6_edge;
    assign o_pix  = r6_pix;

endmodule

@@ rtl/tbr_weight.sv @@
// weighted height sum and offset dividend for the rounding divide (four stages)
module tbr_weight (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  logic                      i_vld,
    input  tbr_pkg::t_edge            i_edge,
    input  tbr_pkg::t_pix             i_pix,
    input  tbr_pkg::t_vertex          i_vtx_a,
    input  tbr_pkg::t_vertex          i_vtx_b,
    input  tbr_pkg::t_vertex          i_vtx_c,
    output logic                      o_vld,
    output logic [tbr_pkg::NUM_W-1:0] o_num,
    output logic [tbr_pkg::DEN_W-1:0] o_den,
    output tbr_pkg::t_side            o_side
);

    // stage 7: z split into signed high and unsigned low halves times each weight
    logic signed [50:0] n7_ph1, n7_ph2, n7_ph3;
    logic [49:0]        n7_pl1, n7_pl2, n7_pl3;
    logic signed [50:0] r7_ph1, r7_ph2, r7_ph3;
    logic [49:0]        r7_pl1, r7_pl2, r7_pl3;
    logic [tbr_pkg::AREA_W-1:0] r7_d;
    tbr_pkg::t_side     r7_side;
    logic               r7_vld;

    always_comb begin
        n7_ph1 = $signed(i_vtx_a.z[31:16]) * $signed({1'b0, i_edge.n1});
        n7_ph2 = $signed(i_vtx_b.z[31:16]) * $signed({1'b0, i_edge.n2});
        n7_ph3 = $signed(i_vtx_c.z[31:16]) * $signed({1'b0, i_edge.n3});
        n7_pl1 = i_vtx_a.z[15:0] * i_edge.n1;
        n7_pl2 = i_vtx_b.z[15:0] * i_edge.n2;
        n7_pl3 = i_vtx_c.z[15:0] * i_edge.n3;
    end

    // stage 8: sums
    logic signed [52:0] n8_hsum;
    logic [51:0]        n8_lsum;
    logic signed [52:0] r8_hsum;
    logic [51:0]        r8_lsum;
    logic [tbr_pkg::AREA_W-1:0] r8_d;
    tbr_pkg::t_side     r8_side;
    logic               r8_vld;

    always_comb begin
        n8_hsum = r7_ph1 + r7_ph2 + r7_ph3;
        n8_lsum = {2'b0, r7_pl1} + {2'b0, r7_pl2} + {2'b0, r7_pl3};
    end

    // stage 9: twice the full sum, and d*(2^32+1) which adds the half step and the
    // offset that keeps the quotient non-negative
    logic signed [69:0] n9_a;
    logic [65:0]        n9_b;
    logic signed [69:0] r9_a;
    logic [65:0]        r9_b;
    logic [tbr_pkg::AREA_W-1:0] r9_d;
    tbr_pkg::t_side     r9_side;
    logic               r9_vld;

    always_comb begin
        n9_a = $signed({r8_hsum, 17'b0}) + $signed({17'b0, r8_lsum, 1'b0});
        n9_b = {r8_d, 32'b0} + {32'b0, r8_d};
    end

    // stage 10: dividend and divisor 2d
    logic signed [69:0]        n10_sum;
    logic [tbr_pkg::NUM_W-1:0] r10_num;
    logic [tbr_pkg::DEN_W-1:0] r10_den;
    tbr_pkg::t_side            r10_side;
    logic                      r10_vld;

    always_comb begin
        n10_sum = r9_a + $signed({4'b0, r9_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else if (i_ce) begin
            r7_vld  <= i_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r7_ph1       <= n7_ph1;
            r7_ph2       <= n7_ph2;
            r7_ph3       <= n7_ph3;
            r7_pl1       <= n7_pl1;
            r7_pl2       <= n7_pl2;
            r7_pl3       <= n7_pl3;
            r7_d         <= i_edge.d;
            r7_side.en   <= i_edge.in_tri;
            r7_side.pix  <= i_pix;

            r8_hsum <= n8_hsum;
            r8_lsum <= n8_lsum;
            r8_d    <= r7_d;
            r8_side <= r7_side;

            r9_a    <= n9_a;
            r9_b    <= n9_b;
            r9_d    <= r8_d;
            r9_side <= r8_side;

            r10_num  <= n10_sum[tbr_pkg::NUM_W-1:0];
            r10_den  <= {r9_d, 1'b0};
            r10_side <= r9_side;
        end
    end

    assign o_vld  = r10_vld;
    assign o_num  = r10_num;
    assign o_den  = r10_den;
    assign o_side = r10_side;

endmodule

@@ rtl/tbr_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with result formatting
module tbr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  logic                      i_vld,
    input  logic [tbr_pkg::NUM_W-1:0] i_num,
    input  logic [tbr_pkg::DEN_W-1:0] i_den,
    input  tbr_pkg::t_side            i_side,
    output logic                      o_vld,
    output logic                      o_write_enable,
    output logic signed [31:0]        o_height,
    output tbr_pkg::t_pix             o_pix
);

    localparam int unsigned Steps = tbr_pkg::QUO_W;

    logic [tbr_pkg::DEN_W-1:0] r_rem  [0:Steps];
    logic [tbr_pkg::QUO_W-1:0] r_low  [0:Steps];
    logic [tbr_pkg::QUO_W-1:0] r_quo  [0:Steps];
    logic [tbr_pkg::DEN_W-1:0] r_den  [0:Steps];
    tbr_pkg::t_side            r_side [0:Steps];
    logic                      r_vld  [0:Steps];

    // load: the upper part of the dividend is already below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= i_num[tbr_pkg::NUM_W-1:tbr_pkg::QUO_W];
            r_low[0]  <= i_num[tbr_pkg::QUO_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= Steps; k++) begin : g_step
        logic [tbr_pkg::DEN_W:0]   w_trial;
        logic [tbr_pkg::DEN_W+1:0] w_diff;
        logic                      w_ge;
        logic [tbr_pkg::DEN_W-1:0] w_rem;
        logic [tbr_pkg::QUO_W-1:0] w_quo;

        always_comb begin
            w_trial = {r_rem[k-1], r_low[k-1][tbr_pkg::QUO_W-1]};
            w_diff  = {1'b0, w_trial} - {2'b0, r_den[k-1]};
            w_ge    = !w_diff[tbr_pkg::DEN_W+1];
            w_rem   = w_ge ? w_diff[tbr_pkg::DEN_W-1:0] : w_trial[tbr_pkg::DEN_W-1:0];
            w_quo   = {r_quo[k-1][tbr_pkg::QUO_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        if (k == Steps) begin : g_last
            // remove the 2^31 offset; height is zero when not written
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_quo[k] <= r_side[k-1].en ?
                                {~w_quo[tbr_pkg::QUO_W-1], w_quo[tbr_pkg::QUO_W-2:0]} : '0;
                    r_rem[k]  <= w_rem;
                    r_low[k]  <= {r_low[k-1][tbr_pkg::QUO_W-2:0], 1'b0};
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_quo[k]  <= w_quo;
                    r_rem[k]  <= w_rem;
                    r_low[k]  <= {r_low[k-1][tbr_pkg::QUO_W-2:0], 1'b0};
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_vld          = r_vld[Steps];
    assign o_write_enable = r_side[Steps].en;
    assign o_height       = $signed(r_quo[Steps]);
    assign o_pix          = r_side[Steps].pix;

endmodule

@@ rtl/triangle_barycentric_raster.sv @@
// Barycentric triangle rasterizer: one pixel test and height interpolation per clock when not stalled.
// The block takes one pixel per clock when the output is not stalled and passes it through six stages
// of edge functions and inside tests, four stages of weighted height sums, a load stage and
// a 32-stage restoring divider that yields one bit of the rounded height per stage. The
// whole pipeline advances together; while a result is held at the output with
// m_axis_tready low, the pipeline and the input stall, and nothing is lost or repeated.
// The user must write vertices and raster size through the configuration port only while no
// pixel is in flight; the block does not enforce this. A raster size above 4096 acts as 4096.
module triangle_barycentric_raster (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [tbr_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [63:0]                 i_cfg_wdata,
    // pixel requests
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,  // pixel_column[11:0], pixel_row[23:12]
    // results
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [55:0]                 m_axis_tdata,  // height_value[31:0], memory_row[43:32],
                                                       // memory_column[55:44]
    output logic [0:0]                  m_axis_tuser   // write_enable[0]
);

    tbr_pkg::t_vertex          r_vtx_a, r_vtx_b, r_vtx_c;
    logic [tbr_pkg::DIM_W-1:0] r_raster_w, r_raster_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a    <= '0;
            r_vtx_b    <= '0;
            r_vtx_c    <= '0;
            r_raster_w <= '0;
            r_raster_h <= '0;
        end else if (i_cfg_we) begin
            case (tbr_pkg::t_cfg_addr'(i_cfg_addr))
                tbr_pkg::CFG_VERTEX_A:      r_vtx_a    <= i_cfg_wdata;
                tbr_pkg::CFG_VERTEX_B:      r_vtx_b    <= i_cfg_wdata;
                tbr_pkg::CFG_VERTEX_C:      r_vtx_c    <= i_cfg_wdata;
                tbr_pkg::CFG_RASTER_WIDTH:  r_raster_w <= i_cfg_wdata[tbr_pkg::DIM_W-1:0];
                tbr_pkg::CFG_RASTER_HEIGHT: r_raster_h <= i_cfg_wdata[tbr_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic                      w_ce;
    logic                      w_edge_vld;
    tbr_pkg::t_edge            w_edge;
    tbr_pkg::t_pix             w_edge_pix;
    logic                      w_wt_vld;
    logic [tbr_pkg::NUM_W-1:0] w_num;
    logic [tbr_pkg::DEN_W-1:0] w_den;
    tbr_pkg::t_side            w_side;
    logic                      w_out_vld;
    logic                      w_out_we;
    logic signed [31:0]        w_out_height;
    tbr_pkg::t_pix             w_out_pix;

    // the pipeline moves whenever the output slot is free or being taken
    assign w_ce          = m_axis_tready || !w_out_vld;
    assign s_axis_tready = w_ce;

    tbr_edge u_edge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (w_ce),
        .i_vld      (s_axis_tvalid),
        .i_col      (s_axis_tdata[11:0]),
        .i_row      (s_axis_tdata[23:12]),
        .i_vtx_a    (r_vtx_a),
        .i_vtx_b    (r_vtx_b),
        .i_vtx_c    (r_vtx_c),
        .i_raster_w (r_raster_w),
        .i_raster_h (r_raster_h),
        .o_vld      (w_edge_vld),
        .o_edge     (w_edge),
        .o_pix      (w_edge_pix)
    );

    tbr_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (w_edge_vld),
        .i_edge  (w_edge),
        .i_pix   (w_edge_pix),
        .i_vtx_a (r_vtx_a),
        .i_vtx_b (r_vtx_b),
        .i_vtx_c (r_vtx_c),
        .o_vld   (w_wt_vld),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_side)
    );

    tbr_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ce           (w_ce),
        .i_vld          (w_wt_vld),
        .i_num          (w_num),
        .i_den          (w_den),
        .i_side         (w_side),
        .o_vld          (w_out_vld),
        .o_write_enable (w_out_we),
        .o_height       (w_out_height),
        .o_pix          (w_out_pix)
    );

    assign m_axis_tvalid = w_out_vld;
    assign m_axis_tdata  = {w_out_pix.mem_col, w_out_pix.mem_row, w_out_height};
    assign m_axis_tuser  = w_out_we;

endmodule
